FILE: hw/rtl/stepper_trapezoid_ramp_defines.svh
// Assertion macros shared by the stepper ramp RTL.
`ifndef STEPPER_TRAPEZOID_RAMP_DEFINES_SVH
`define STEPPER_TRAPEZOID_RAMP_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define STRAMP_ASSERT_NOW(label, clk_s, rst_s, ante, cons, msg) \
  label: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define STRAMP_ASSERT_NEXT(label, clk_s, rst_s, ante, cons, msg) \
  label: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hw/rtl/stramp_pkg.sv
// Types, constants and register map for the stepper trapezoid ramp.
package stramp_pkg;

  localparam int CNT_W  = 20;   // step counter width
  localparam int ACC_W  = 20;   // accel/decel step count register width
  localparam int CMP_W  = (CNT_W > ACC_W) ? CNT_W : ACC_W;
  localparam int RATE_W = 14;
  localparam int INC_W  = 8;
  localparam int IVL_W  = 16;
  localparam int PER_W  = 20;
  localparam int DIVD_W = 20;   // dividend: 1e6 < 2^20
  localparam int DCNT_W = 5;    // iteration counter, holds DIVD_W
  localparam int MM_W   = 16;
  localparam int ADDR_W = 5;

  localparam logic [DIVD_W-1:0] US_PER_S   = 20'd1000000;
  localparam logic [RATE_W-1:0] MM_DIVISOR = 14'd13;
  localparam logic [6:0]        MM_FACTOR  = 7'd106;
  // ceil(2^21 / 13); exact floor(x/13) for x < 2^17
  localparam logic [MM_W+1:0]   MM_RECIP    = 18'd161320;
  localparam int                MM_RECIP_SH = 21;

  // Register indexes (paddr[4:2])
  localparam logic [2:0] REG_START_RATE  = 3'd0;
  localparam logic [2:0] REG_MAX_RATE    = 3'd1;
  localparam logic [2:0] REG_FINISH_RATE = 3'd2;
  localparam logic [2:0] REG_RATE_INC    = 3'd3;
  localparam logic [2:0] REG_RAMP_IVL    = 3'd4;
  localparam logic [2:0] REG_ACCEL_STEPS = 3'd5;
  localparam logic [2:0] REG_DECEL_STEPS = 3'd6;

  typedef struct packed {
    logic [RATE_W-1:0] start_rate;
    logic [RATE_W-1:0] max_rate;
    logic [RATE_W-1:0] finish_rate;
    logic [INC_W-1:0]  rate_increment;
    logic [IVL_W-1:0]  ramp_interval_us;
    logic [ACC_W-1:0]  accel_step_count;
    logic [ACC_W-1:0]  decel_step_count;
  } stramp_cfg_t;

  typedef enum logic [3:0] {
    PH_IDLE   = 4'b0001,
    PH_ACCEL  = 4'b0010,
    PH_CRUISE = 4'b0100,
    PH_DECEL  = 4'b1000
  } phase_t;

  // Controller -> datapath
  typedef struct packed {
    logic load_move;   // latch direction, start rate, clear counters
    logic clr_done;
    logic div_start;
    logic set_steps;
    logic set_period;
    logic tick_step;
    logic tick_ramp;
    logic out_load;
  } stramp_cmd_t;

  // Datapath -> controller
  typedef struct packed {
    logic div_busy;
    logic div_done;
    logic phase_idle;
    logic tick_end;
    logic rate_chg;
  } stramp_sts_t;

endpackage

FILE: hw/rtl/stramp_if.sv
// Input and result channel interfaces.
interface stramp_in_if;
  import stramp_pkg::*;
  logic            valid;
  logic            ready;
  logic            req_type;
  logic [MM_W-1:0] distance_mm;
  logic            forward;

  modport source (output valid, req_type, distance_mm, forward, input ready);
  modport sink (input valid, req_type, distance_mm, forward, output ready);
endinterface

interface stramp_out_if;
  import stramp_pkg::*;
  logic              valid;
  logic              ready;
  logic              step_level;
  logic              left_dir_level;
  logic              right_dir_level;
  logic              enable_n;
  logic              done_res;
  logic              busy_res;
  logic [RATE_W-1:0] step_rate;

  modport source (output valid, step_level, left_dir_level, right_dir_level, enable_n,
                  done_res, busy_res, step_rate, input ready);
  modport sink (input valid, step_level, left_dir_level, right_dir_level, enable_n,
                done_res, busy_res, step_rate, output ready);
endinterface

FILE: hw/rtl/stepper_trapezoid_ramp.sv
// Top level: register port, controller and datapath of the stepper ramp.
//
//  channel  direction  transfer on           payload
//  in_ch    sink       valid & ready         req_type, distance_mm, forward
//  out_ch   source     valid & ready         step/dir/enable levels, done, busy, rate
//  APB      slave      psel&penable&pwrite   7 registers at 4*index
//
// Tick while idle or on the last step: S_TICK_STEP, then S_RESULT loads the result.
// Other ticks add S_TICK_RAMP; a rate change adds a restoring divide in S_DIV_PERIOD.
// Move: step count by reciprocal multiply, then one divider pass for 1e6/start rate.
// One item in flight; the next is taken once the result register is free or drains.
// rst_n is synchronous, active low, and restores the register defaults.
module stepper_trapezoid_ramp import stramp_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  stramp_in_if.sink         in_ch,
  stramp_out_if.source      out_ch,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  stramp_cfg_t cfg_r, cfg_nxt;
  stramp_cmd_t cmd;
  stramp_sts_t sts;
  logic        wr_en;
  logic [2:0]  reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[4:2];

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (reg_idx)
        REG_START_RATE:  cfg_nxt.start_rate       = pwdata[RATE_W-1:0];
        REG_MAX_RATE:    cfg_nxt.max_rate         = pwdata[RATE_W-1:0];
        REG_FINISH_RATE: cfg_nxt.finish_rate      = pwdata[RATE_W-1:0];
        REG_RATE_INC:    cfg_nxt.rate_increment   = pwdata[INC_W-1:0];
        REG_RAMP_IVL:    cfg_nxt.ramp_interval_us = pwdata[IVL_W-1:0];
        REG_ACCEL_STEPS: cfg_nxt.accel_step_count = pwdata[ACC_W-1:0];
        REG_DECEL_STEPS: cfg_nxt.decel_step_count = pwdata[ACC_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_START_RATE:  prdata = 32'(cfg_r.start_rate);
      REG_MAX_RATE:    prdata = 32'(cfg_r.max_rate);
      REG_FINISH_RATE: prdata = 32'(cfg_r.finish_rate);
      REG_RATE_INC:    prdata = 32'(cfg_r.rate_increment);
      REG_RAMP_IVL:    prdata = 32'(cfg_r.ramp_interval_us);
      REG_ACCEL_STEPS: prdata = 32'(cfg_r.accel_step_count);
      REG_DECEL_STEPS: prdata = 32'(cfg_r.decel_step_count);
      default:         prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.start_rate       <= 14'd1000;
      cfg_r.max_rate         <= 14'd9000;
      cfg_r.finish_rate      <= 14'd1000;
      cfg_r.rate_increment   <= 8'd2;
      cfg_r.ramp_interval_us <= 16'd2000;
      cfg_r.accel_step_count <= 20'd40000;
      cfg_r.decel_step_count <= 20'd40000;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  stramp_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_ch.valid),
    .in_req_type (in_ch.req_type),
    .in_ready    (in_ch.ready),
    .out_valid   (out_ch.valid),
    .out_ready   (out_ch.ready),
    .cmd         (cmd),
    .sts         (sts)
  );

  stramp_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg             (cfg_r),
    .cmd             (cmd),
    .sts             (sts),
    .in_distance_mm  (in_ch.distance_mm),
    .in_forward      (in_ch.forward),
    .step_level      (out_ch.step_level),
    .left_dir_level  (out_ch.left_dir_level),
    .right_dir_level (out_ch.right_dir_level),
    .enable_n        (out_ch.enable_n),
    .done_res        (out_ch.done_res),
    .busy_res        (out_ch.busy_res),
    .step_rate       (out_ch.step_rate)
  );

endmodule

FILE: hw/rtl/stramp_div.sv
// Restoring divider, one quotient bit per cycle.
module stramp_div import stramp_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [DIVD_W-1:0] dividend,
  input  logic [RATE_W-1:0] divisor,
  output logic              busy,
  output logic              done,
  output logic [DIVD_W-1:0] quotient
);

  logic [DIVD_W-1:0] q_r, q_nxt;
  logic [RATE_W-1:0] rem_r, rem_nxt;
  logic [RATE_W-1:0] dvs_r, dvs_nxt;
  logic [DCNT_W-1:0] cnt_r, cnt_nxt;
  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [RATE_W:0]   trial;
  logic              fits;

  assign trial = {rem_r, q_r[DIVD_W-1]};
  assign fits  = trial >= {1'b0, dvs_r};

  always_comb begin
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      q_nxt    = dividend;
      rem_nxt  = '0;
      dvs_nxt  = divisor;
      cnt_nxt  = DCNT_W'(DIVD_W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      // divisor of zero gives an all-ones quotient
      rem_nxt = fits ? RATE_W'(trial - {1'b0, dvs_r}) : trial[RATE_W-1:0];
      q_nxt   = {q_r[DIVD_W-2:0], fits};
      cnt_nxt = cnt_r - DCNT_W'(1);
      if (cnt_r == DCNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  assign busy     = busy_r;
  assign done     = done_r;
  assign quotient = q_r;

endmodule

FILE: hw/rtl/stramp_dp.sv
// Ramp datapath: step/interval counters, rate update, period divider, result register.
module stramp_dp import stramp_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  stramp_cfg_t       cfg,
  input  stramp_cmd_t       cmd,
  output stramp_sts_t       sts,
  input  logic [MM_W-1:0]   in_distance_mm,
  input  logic              in_forward,
  output logic              step_level,
  output logic              left_dir_level,
  output logic              right_dir_level,
  output logic              enable_n,
  output logic              done_res,
  output logic              busy_res,
  output logic [RATE_W-1:0] step_rate
);

  logic [CNT_W-1:0]  steps_left_r, steps_left_nxt;
  logic [CNT_W-1:0]  steps_total_r, steps_total_nxt;
  logic [RATE_W-1:0] rate_r, rate_nxt;
  logic [PER_W-1:0]  period_r, period_nxt;
  logic [PER_W-1:0]  pcount_r, pcount_nxt;
  logic [IVL_W-1:0]  icount_r, icount_nxt;
  phase_t            phase_r, phase_nxt;
  logic              ramp_en_r, ramp_en_nxt;
  logic              pin_r, pin_nxt;
  logic              dir_r, dir_nxt;
  logic              done_r, done_nxt;

  // result register
  logic              o_step_r, o_dir_r, o_busy_r, o_done_r;
  logic [RATE_W-1:0] o_rate_r;

  // divider
  logic [DIVD_W-1:0] div_dividend, div_q;
  logic [RATE_W-1:0] div_divisor;
  logic              div_busy, div_done;

  // step count from distance
  logic [MM_W:0]     mm_x2;
  logic [2*MM_W+2:0] mm_prod;
  logic [CNT_W-1:0]  mm_steps;

  // step stage
  logic [PER_W-1:0]  pc_inc;
  logic              p_fire;
  logic [CNT_W-1:0]  sl_dec;
  logic              last_step;
  logic              decel_hit;

  // ramp stage
  logic [IVL_W-1:0]  ic_inc;
  logic              ramp_act, iv_fire;
  logic [CNT_W-1:0]  taken;
  logic              acc_go;
  logic [RATE_W:0]   r_up, fin_plus;
  logic [RATE_W-1:0] r_cap, r_dn;
  logic              new_zero;

  // mm*106/13 = 8*mm + floor(2*mm/13)
  assign mm_x2    = {in_distance_mm, 1'b0};
  assign mm_prod  = (2*MM_W+3)'(mm_x2) * (2*MM_W+3)'(MM_RECIP);
  assign mm_steps = CNT_W'({in_distance_mm, 3'b000}) +
                    CNT_W'(mm_prod[2*MM_W+2:MM_RECIP_SH]);

  assign div_dividend = US_PER_S;
  assign div_divisor  = rate_nxt;

  stramp_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .busy     (div_busy),
    .done     (div_done),
    .quotient (div_q)
  );

  assign pc_inc    = pcount_r + PER_W'(1);
  assign p_fire    = pc_inc >= period_r;
  assign sl_dec    = steps_left_r - CNT_W'(1);
  assign last_step = sl_dec == '0;
  assign decel_hit = ramp_en_r && (phase_r != PH_DECEL) &&
                     (CMP_W'(sl_dec) <= CMP_W'(cfg.decel_step_count));

  assign ic_inc   = icount_r + IVL_W'(1);
  assign ramp_act = (phase_r == PH_ACCEL) || (phase_r == PH_DECEL);
  assign iv_fire  = ic_inc >= cfg.ramp_interval_us;
  assign taken    = steps_total_r - steps_left_r;
  assign acc_go   = CMP_W'(taken) < CMP_W'(cfg.accel_step_count);
  assign r_up     = {1'b0, rate_r} + (RATE_W+1)'(cfg.rate_increment);
  assign r_cap    = (r_up > {1'b0, cfg.max_rate}) ? cfg.max_rate : r_up[RATE_W-1:0];
  assign fin_plus = {1'b0, cfg.finish_rate} + (RATE_W+1)'(cfg.rate_increment);
  assign r_dn     = ({1'b0, rate_r} <= fin_plus) ? cfg.finish_rate
                                                 : rate_r - RATE_W'(cfg.rate_increment);

  assign new_zero = mm_steps == '0;

  always_comb begin
    steps_left_nxt  = steps_left_r;
    steps_total_nxt = steps_total_r;
    rate_nxt        = rate_r;
    period_nxt      = period_r;
    pcount_nxt      = pcount_r;
    icount_nxt      = icount_r;
    phase_nxt       = phase_r;
    ramp_en_nxt     = ramp_en_r;
    pin_nxt         = pin_r;
    dir_nxt         = dir_r;
    done_nxt        = done_r;

    if (cmd.clr_done) begin
      done_nxt = 1'b0;
    end
    if (cmd.load_move) begin
      pin_nxt    = 1'b0;
      dir_nxt    = in_forward;
      rate_nxt   = cfg.start_rate;
      pcount_nxt = '0;
      icount_nxt = '0;
    end
    if (cmd.set_steps) begin
      steps_total_nxt = mm_steps;
      steps_left_nxt  = mm_steps;
      if (new_zero) begin
        phase_nxt   = PH_IDLE;
        ramp_en_nxt = 1'b0;
        done_nxt    = 1'b1;
      end else if ((CMP_W+1)'(mm_steps) >
                   (CMP_W+1)'(cfg.accel_step_count) + (CMP_W+1)'(cfg.decel_step_count)) begin
        phase_nxt   = PH_ACCEL;
        ramp_en_nxt = 1'b1;
      end else begin
        phase_nxt   = PH_CRUISE;
        ramp_en_nxt = 1'b0;
      end
    end
    if (cmd.set_period) begin
      period_nxt = PER_W'(div_q);
    end
    if (cmd.tick_step && (phase_r != PH_IDLE)) begin
      if (p_fire) begin
        pcount_nxt     = '0;
        pin_nxt        = !pin_r;
        steps_left_nxt = sl_dec;
        if (last_step) begin
          phase_nxt   = PH_IDLE;
          ramp_en_nxt = 1'b0;
          done_nxt    = 1'b1;
        end else if (decel_hit) begin
          phase_nxt  = PH_DECEL;
          icount_nxt = '0;
        end
      end else begin
        pcount_nxt = pc_inc;
      end
    end
    if (cmd.tick_ramp && ramp_act) begin
      if (iv_fire) begin
        icount_nxt = '0;
        if (phase_r == PH_DECEL) begin
          rate_nxt   = r_dn;
          pcount_nxt = '0;
        end else if (acc_go) begin
          rate_nxt   = r_cap;
          pcount_nxt = '0;
        end else begin
          phase_nxt = PH_CRUISE;
        end
      end else begin
        icount_nxt = ic_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      steps_left_r  <= '0;
      steps_total_r <= '0;
      rate_r        <= '0;
      period_r      <= '0;
      pcount_r      <= '0;
      icount_r      <= '0;
      phase_r       <= PH_IDLE;
      ramp_en_r     <= 1'b0;
      pin_r         <= 1'b0;
      dir_r         <= 1'b0;
      done_r        <= 1'b0;
    end else begin
      steps_left_r  <= steps_left_nxt;
      steps_total_r <= steps_total_nxt;
      rate_r        <= rate_nxt;
      period_r      <= period_nxt;
      pcount_r      <= pcount_nxt;
      icount_r      <= icount_nxt;
      phase_r       <= phase_nxt;
      ramp_en_r     <= ramp_en_nxt;
      pin_r         <= pin_nxt;
      dir_r         <= dir_nxt;
      done_r        <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      o_step_r <= pin_r;
      o_dir_r  <= dir_r;
      o_busy_r <= phase_r != PH_IDLE;
      o_done_r <= done_r;
      o_rate_r <= rate_r;
    end
  end

  assign sts.div_busy   = div_busy;
  assign sts.div_done   = div_done;
  assign sts.phase_idle = phase_r == PH_IDLE;
  assign sts.tick_end   = p_fire && last_step;
  assign sts.rate_chg   = ramp_act && iv_fire && ((phase_r == PH_DECEL) || acc_go);

  assign step_level      = o_step_r;
  assign left_dir_level  = o_dir_r;
  assign right_dir_level = !o_dir_r;
  assign enable_n        = !o_busy_r;
  assign busy_res        = o_busy_r;
  assign done_res        = o_done_r;
  assign step_rate       = o_rate_r;

endmodule

FILE: hw/rtl/stramp_ctrl.sv
// Sequencing state machine for moves and ticks.
`include "stepper_trapezoid_ramp_defines.svh"

module stramp_ctrl import stramp_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_req_type,
  output logic        in_ready,
  output logic        out_valid,
  input  logic        out_ready,
  output stramp_cmd_t cmd,
  input  stramp_sts_t sts
);

  typedef enum logic [4:0] {
    S_IDLE       = 5'b00001,
    S_DIV_PERIOD = 5'b00010,
    S_TICK_STEP  = 5'b00100,
    S_TICK_RAMP  = 5'b01000,
    S_RESULT     = 5'b10000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   in_acc;

  assign in_ready = (state_r == S_IDLE) && (!out_valid_r || out_ready);
  assign in_acc   = in_valid && in_ready;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          cmd.clr_done = 1'b1;
          if (in_req_type) begin
            cmd.load_move = 1'b1;
            cmd.set_steps = 1'b1;
            cmd.div_start = 1'b1;
            state_nxt     = S_DIV_PERIOD;
          end else begin
            state_nxt = S_TICK_STEP;
          end
        end
      end
      S_DIV_PERIOD: begin
        if (sts.div_done) begin
          cmd.set_period = 1'b1;
          state_nxt      = S_RESULT;
        end
      end
      S_TICK_STEP: begin
        cmd.tick_step = 1'b1;
        if (sts.phase_idle || sts.tick_end) begin
          state_nxt = S_RESULT;
        end else begin
          state_nxt = S_TICK_RAMP;
        end
      end
      S_TICK_RAMP: begin
        cmd.tick_ramp = 1'b1;
        if (sts.rate_chg) begin
          cmd.div_start = 1'b1;
          state_nxt     = S_DIV_PERIOD;
        end else begin
          state_nxt = S_RESULT;
        end
      end
      S_RESULT: begin
        cmd.out_load = 1'b1;
        state_nxt    = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

  `STRAMP_ASSERT_NOW(a_div_start_idle, clk, rst_n, cmd.div_start, !sts.div_busy,
    "divider started while busy")
  `STRAMP_ASSERT_NOW(a_div_done_expected, clk, rst_n, sts.div_done,
    state_r == S_DIV_PERIOD,
    "divider result outside a divide state")
  `STRAMP_ASSERT_NOW(a_no_result_overwrite, clk, rst_n, cmd.out_load,
    !out_valid_r || out_ready, "result register loaded over an untaken result")
  `STRAMP_ASSERT_NEXT(a_end_goes_idle, clk, rst_n,
    (state_r == S_TICK_STEP) && !sts.phase_idle && sts.tick_end, sts.phase_idle,
    "move end did not return the phase to idle")

endmodule
